// File: rtl/assert_macros.svh
// shared assertion macros, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CSMAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CSMAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/csmab_pkg.sv
`default_nettype none
package csmab_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CW_W    = 10;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned WAIT_W  = CW_W + TIME_W;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;

  // input function codes
  localparam logic [FUNC_W-1:0] FN_FRAME_REQ = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CHECK_RES = 2'd1;
  localparam logic [FUNC_W-1:0] FN_BURST_ACK = 2'd2;
  localparam logic [FUNC_W-1:0] FN_TICK      = 2'd3;

  // result kinds
  localparam logic EV_CHECK_REQ = 1'b0;
  localparam logic EV_RELEASE   = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_CCA_ENABLE   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DCF_MODE     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_POST_TX_BO   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BURST_ACK_EN = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MIN_CW       = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SLOT_TIME    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_DIFS_TIME    = 3'd6;

  localparam logic [CW_W-1:0]   MIN_CW_RST    = 10'd31;
  localparam logic [TIME_W-1:0] SLOT_TIME_RST = 16'd1000;
  localparam logic [TIME_W-1:0] DIFS_TIME_RST = 16'd2000;

  typedef struct packed {
    logic              cca_enable;
    logic              dcf_mode;
    logic              post_tx_backoff_enable;
    logic              burst_ack_enable;
    logic [CW_W-1:0]   min_cw;
    logic [TIME_W-1:0] slot_time;
    logic [TIME_W-1:0] difs_time;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              is_data;
    logic              channel_free;
    logic [CW_W-1:0]   random_value;
  } in_item_t;

  typedef struct packed {
    logic              event_kind;
    logic [TIME_W-1:0] check_duration;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/csmab_ifs.sv
`default_nettype none
interface csmab_in_if import csmab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              is_data;
  logic              channel_free;
  logic [CW_W-1:0]   random_value;

  modport source (output valid, func, is_data, channel_free, random_value, input ready);
  modport sink (input valid, func, is_data, channel_free, random_value, output ready);
endinterface

interface csmab_out_if import csmab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              event_kind;
  logic [TIME_W-1:0] check_duration;

  modport source (output valid, event_kind, check_duration, input ready);
  modport sink (input valid, event_kind, check_duration, output ready);
endinterface

interface csmab_cfg_if import csmab_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/csmab_cfg_regs.sv
`default_nettype none
module csmab_cfg_regs import csmab_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [CIDX_W-1:0]  wr_index,
  input  wire logic [CDATA_W-1:0] wr_data,
  output cfg_t                    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_CCA_ENABLE:   cfg_nxt.cca_enable = wr_data[0];
        REG_DCF_MODE:     cfg_nxt.dcf_mode = wr_data[0];
        REG_POST_TX_BO:   cfg_nxt.post_tx_backoff_enable = wr_data[0];
        REG_BURST_ACK_EN: cfg_nxt.burst_ack_enable = wr_data[0];
        REG_MIN_CW:       cfg_nxt.min_cw = wr_data[CW_W-1:0];
        REG_SLOT_TIME:    cfg_nxt.slot_time = wr_data[TIME_W-1:0];
        REG_DIFS_TIME:    cfg_nxt.difs_time = wr_data[TIME_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cca_enable             <= 1'b1;
      cfg_r.dcf_mode               <= 1'b1;
      cfg_r.post_tx_backoff_enable <= 1'b1;
      cfg_r.burst_ack_enable       <= 1'b1;
      cfg_r.min_cw                 <= MIN_CW_RST;
      cfg_r.slot_time              <= SLOT_TIME_RST;
      cfg_r.difs_time              <= DIFS_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: rtl/csmab_core.sv
`default_nettype none
module csmab_core import csmab_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output result_t   res
);

  `include "assert_macros.svh"

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WAIT_ACK  = 3'd1;
  localparam logic [2:0] PH_WAIT_POST = 3'd2;
  localparam logic [2:0] PH_DIFS      = 3'd3;
  localparam logic [2:0] PH_SLOT      = 3'd4;
  localparam logic [2:0] PH_SENSE     = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic              pending_r, pending_nxt;
  logic              ack_owed_r, ack_owed_nxt;
  logic [WAIT_W-1:0] post_wait_r, post_wait_nxt;
  logic [CW_W-1:0]   slots_r, slots_nxt;

  logic [CW_W-1:0]   draw;
  logic [CW_W-1:0]   slots_dec;
  logic [WAIT_W-1:0] post_draw;
  logic              go_after_ack;
  logic              go_sense;
  logic              go_release;

  assign draw      = item.random_value & cfg.min_cw;
  assign slots_dec = slots_r - CW_W'(1);
  assign post_draw = {{TIME_W{1'b0}}, draw} * {{CW_W{1'b0}}, cfg.slot_time};

  always_comb begin
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    ack_owed_nxt  = ack_owed_r;
    post_wait_nxt = post_wait_r;
    slots_nxt     = slots_r;
    go_after_ack  = 1'b0;
    go_sense      = 1'b0;
    go_release    = 1'b0;
    res           = '0;

    case (item.func)
      FN_FRAME_REQ: begin
        if (phase_r == PH_IDLE) begin
          pending_nxt = item.is_data;
          if (cfg.burst_ack_enable && ack_owed_r) begin
            phase_nxt = PH_WAIT_ACK;
          end else begin
            go_after_ack = 1'b1;
          end
        end
      end
      FN_CHECK_RES: begin
        if (phase_r == PH_DIFS) begin
          if (item.channel_free) begin
            go_release = 1'b1;
          end else begin
            slots_nxt = draw;
            if (draw == '0) begin
              go_release = 1'b1;
            end else begin
              phase_nxt = PH_SLOT;
              res       = '{valid: 1'b1, item: '{EV_CHECK_REQ, cfg.slot_time}};
            end
          end
        end else if (phase_r == PH_SLOT) begin
          if (item.channel_free) begin
            slots_nxt = slots_dec;
          end
          if (item.channel_free && slots_dec == '0) begin
            go_release = 1'b1;
          end else begin
            res = '{valid: 1'b1, item: '{EV_CHECK_REQ, cfg.slot_time}};
          end
        end else if (phase_r == PH_SENSE) begin
          if (item.channel_free) begin
            go_release = 1'b1;
          end else begin
            res = '{valid: 1'b1, item: '{EV_CHECK_REQ, '0}};
          end
        end
      end
      FN_BURST_ACK: begin
        if (ack_owed_r) begin
          ack_owed_nxt = 1'b0;
          go_after_ack = (phase_r == PH_WAIT_ACK);
        end
      end
      default: begin
        if (post_wait_r != '0) begin
          post_wait_nxt = post_wait_r - WAIT_W'(1);
          go_sense = (post_wait_r == WAIT_W'(1)) && (phase_r == PH_WAIT_POST);
        end
      end
    endcase

    // the post-transmit wait must be over before sensing starts
    if (go_after_ack) begin
      if (post_wait_r != '0) begin
        phase_nxt = PH_WAIT_POST;
      end else begin
        go_sense = 1'b1;
      end
    end

    if (go_sense) begin
      if (cfg.cca_enable && pending_nxt) begin
        if (cfg.dcf_mode) begin
          phase_nxt = PH_DIFS;
          res       = '{valid: 1'b1, item: '{EV_CHECK_REQ, cfg.difs_time}};
        end else begin
          phase_nxt = PH_SENSE;
          res       = '{valid: 1'b1, item: '{EV_CHECK_REQ, '0}};
        end
      end else begin
        go_release = 1'b1;
      end
    end

    if (go_release) begin
      ack_owed_nxt = pending_nxt;
      if (cfg.post_tx_backoff_enable && pending_nxt) begin
        post_wait_nxt = post_draw;
      end
      phase_nxt = PH_IDLE;
      res       = '{valid: 1'b1, item: '{EV_RELEASE, '0}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pending_r   <= 1'b0;
      ack_owed_r  <= 1'b0;
      post_wait_r <= '0;
      slots_r     <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      ack_owed_r  <= ack_owed_nxt;
      post_wait_r <= post_wait_nxt;
      slots_r     <= slots_nxt;
    end
  end

  `CSMAB_ASSERT(a_slot_count_live, phase_r != PH_SLOT || slots_r != '0, "slot phase with zero count")
  `CSMAB_ASSERT(a_post_wait_live, phase_r != PH_WAIT_POST || post_wait_r != '0, "waiting on expired timer")
  `CSMAB_ASSERT_NXT(a_release_idle, fire && res.valid && res.item.event_kind == EV_RELEASE, phase_r == PH_IDLE, "release did not return to idle")

endmodule
`default_nettype wire

// File: rtl/csma_backoff_controller.sv
`default_nettype none
// Transmit-access controller with carrier sense and random slot backoff. Frame requests,
// check results, burst acks and microsecond ticks arrive as items on in_chan; channel check
// requests and frame releases leave on out_chan, at most one per item. Every item is taken into
// an input register and handled by one state update that also loads the result register, once
// that register is free or being emptied; a result thus passes the input and result registers
// on its way to out_chan, and one item per cycle is sustained; in_chan stalls only while the
// result register holds a result that out_chan has not taken. The post-transmit wait is one
// 10 x 16 multiply of the masked draw by slot_time in that update. Registers on cfg_chan are
// always accepted and should be written only while no frame is in progress.
module csma_backoff_controller import csmab_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  csmab_in_if.sink   in_chan,
  csmab_out_if.source out_chan,
  csmab_cfg_if.sink  cfg_chan
);

  `include "assert_macros.svh"

  cfg_t      cfg;
  result_t   res;
  in_item_t  in_item_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_item_r;
  logic      out_valid_r, out_valid_nxt;
  logic      fire;
  logic      in_take;

  assign cfg_chan.ready = 1'b1;

  csmab_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  // process the held item whenever the result slot is free or being emptied
  assign fire          = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || fire;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign in_valid_nxt  = in_take || (in_valid_r && !fire);
  assign out_valid_nxt = fire ? res.valid : (out_valid_r && !out_chan.ready);

  csmab_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= '{in_chan.func, in_chan.is_data, in_chan.channel_free, in_chan.random_value};
    end
    if (fire && res.valid) begin
      out_item_r <= res.item;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.event_kind     = out_item_r.event_kind;
  assign out_chan.check_duration = out_item_r.check_duration;

  `CSMAB_ASSERT_NXT(a_held_item_kept, in_valid_r && !fire, in_valid_r && $stable(in_item_r), "held item lost")
  `CSMAB_ASSERT(a_release_no_time, !out_valid_r || out_item_r.event_kind != EV_RELEASE || out_item_r.check_duration == '0, "release with duration")

endmodule
`default_nettype wire

// File: bench/csmab_access_checker.sv
module csmab_access_checker import csmab_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  csmab_in_if  in_chan,
  csmab_out_if out_chan,
  csmab_cfg_if cfg_chan,
  output int   fail_count,
  output int   results_owed,
  output int   progress_count,
  output logic access_idle,
  output logic access_checking
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ACC_IDLE, ACC_WAIT_ACK, ACC_WAIT_POST, ACC_DIFS, ACC_SLOT, ACC_SENSE
  } access_phase_e;

  typedef struct packed {
    access_phase_e     phase;
    logic              pending_data;
    logic              ack_owed;
    logic [WAIT_W-1:0] post_wait_left;
    logic [CW_W-1:0]   slots_left;
  } access_state_t;

  cfg_t          regs;
  access_state_t acc;
  out_item_t     owed_events[$];
  int            fails;
  int            progress;

  function automatic bit release_frame(input logic [CW_W-1:0] rnd, output out_item_t ev);
    acc.ack_owed = acc.pending_data;
    if (regs.post_tx_backoff_enable && acc.pending_data)
      acc.post_wait_left = WAIT_W'(rnd & regs.min_cw) * WAIT_W'(regs.slot_time);
    acc.phase = ACC_IDLE;
    ev.event_kind = EV_RELEASE;
    ev.check_duration = '0;
    return 1'b1;
  endfunction

  function automatic bit start_sensing(input logic [CW_W-1:0] rnd, output out_item_t ev);
    if (regs.cca_enable && acc.pending_data) begin
      ev.event_kind = EV_CHECK_REQ;
      if (regs.dcf_mode) begin
        acc.phase = ACC_DIFS;
        ev.check_duration = regs.difs_time;
      end else begin
        acc.phase = ACC_SENSE;
        ev.check_duration = '0;
      end
      return 1'b1;
    end
    return release_frame(rnd, ev);
  endfunction

  function automatic bit ack_cleared(input logic [CW_W-1:0] rnd, output out_item_t ev);
    ev = '0;
    if (acc.post_wait_left != '0) begin
      acc.phase = ACC_WAIT_POST;
      return 1'b0;
    end
    return start_sensing(rnd, ev);
  endfunction

  // one accepted item; returns 1 when it causes a result
  function automatic bit advance_access(input in_item_t it, output out_item_t ev);
    ev = '0;
    case (it.func)
      FN_FRAME_REQ: begin
        if (acc.phase != ACC_IDLE) return 1'b0;
        acc.pending_data = it.is_data;
        if (regs.burst_ack_enable && acc.ack_owed) begin
          acc.phase = ACC_WAIT_ACK;
          return 1'b0;
        end
        return ack_cleared(it.random_value, ev);
      end
      FN_CHECK_RES: begin
        case (acc.phase)
          ACC_DIFS: begin
            if (it.channel_free) return release_frame(it.random_value, ev);
            acc.slots_left = it.random_value & regs.min_cw;
            if (acc.slots_left == '0) return release_frame(it.random_value, ev);
            acc.phase = ACC_SLOT;
            ev.event_kind = EV_CHECK_REQ;
            ev.check_duration = regs.slot_time;
            return 1'b1;
          end
          ACC_SLOT: begin
            // a busy slot is asked again without counting down
            if (it.channel_free) begin
              acc.slots_left = acc.slots_left - CW_W'(1);
              if (acc.slots_left == '0) return release_frame(it.random_value, ev);
            end
            ev.event_kind = EV_CHECK_REQ;
            ev.check_duration = regs.slot_time;
            return 1'b1;
          end
          ACC_SENSE: begin
            if (it.channel_free) return release_frame(it.random_value, ev);
            ev.event_kind = EV_CHECK_REQ;
            ev.check_duration = '0;
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      FN_BURST_ACK: begin
        if (!acc.ack_owed) return 1'b0;
        acc.ack_owed = 1'b0;
        if (acc.phase == ACC_WAIT_ACK) return ack_cleared(it.random_value, ev);
        return 1'b0;
      end
      default: begin
        if (acc.post_wait_left != '0) begin
          acc.post_wait_left = acc.post_wait_left - WAIT_W'(1);
          if (acc.post_wait_left == '0 && acc.phase == ACC_WAIT_POST)
            return start_sensing(it.random_value, ev);
        end
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    in_item_t      item;
    out_item_t     predicted;
    out_item_t     seen;
    out_item_t     want;
    if (!rst_n) begin
      regs = '{1'b1, 1'b1, 1'b1, 1'b1, MIN_CW_RST, SLOT_TIME_RST, DIFS_TIME_RST};
      acc = '{ACC_IDLE, 1'b0, 1'b0, '0, '0};
      owed_events.delete();
      fails = 0;
      progress = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        seen.event_kind = out_chan.event_kind;
        seen.check_duration = out_chan.check_duration;
        if (owed_events.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got kind %0d duration %0d",
                   $time, seen.event_kind, seen.check_duration);
        end else begin
          want = owed_events.pop_front();
          if (seen.event_kind !== want.event_kind ||
              seen.check_duration !== want.check_duration) begin
            fails++;
            $display("%0t: result mismatch, expected kind %0d duration %0d, got kind %0d duration %0d",
                     $time, want.event_kind, want.check_duration,
                     seen.event_kind, seen.check_duration);
          end
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_CCA_ENABLE:   regs.cca_enable = cfg_chan.data[0];
          REG_DCF_MODE:     regs.dcf_mode = cfg_chan.data[0];
          REG_POST_TX_BO:   regs.post_tx_backoff_enable = cfg_chan.data[0];
          REG_BURST_ACK_EN: regs.burst_ack_enable = cfg_chan.data[0];
          REG_MIN_CW:       regs.min_cw = cfg_chan.data[CW_W-1:0];
          REG_SLOT_TIME:    regs.slot_time = cfg_chan.data[TIME_W-1:0];
          REG_DIFS_TIME:    regs.difs_time = cfg_chan.data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        item.func = in_chan.func;
        item.is_data = in_chan.is_data;
        item.channel_free = in_chan.channel_free;
        item.random_value = in_chan.random_value;
        if (advance_access(item, predicted)) begin
          owed_events.push_back(predicted);
        end
        progress++;
      end
    end
    fail_count <= fails;
    results_owed <= owed_events.size();
    progress_count <= progress;
    access_idle <= (acc.phase == ACC_IDLE);
    access_checking <= (acc.phase == ACC_DIFS || acc.phase == ACC_SLOT ||
                        acc.phase == ACC_SENSE);
  end

endmodule

// File: bench/tb_csma_backoff_controller.sv
module tb_csma_backoff_controller import csmab_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD      = 90;
  localparam int PHASE_ITEMS    = 75;
  localparam int ROUNDS         = 2;
  localparam int LONG_HOLD_PLAN = 6;

  typedef enum int {RX_STREAM, RX_JITTER, RX_STALL} rx_mode_e;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_owed;
  int   progress_count;
  logic access_idle;
  logic access_checking;
  int   burst_left = 0;
  int   hold_requests = 0;
  cfg_t plans [7];

  csmab_in_if  in_chan();
  csmab_out_if out_chan();
  csmab_cfg_if cfg_chan();

  csma_backoff_controller DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  csmab_access_checker u_access_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .cfg_chan        (cfg_chan),
    .fail_count      (fail_count),
    .results_owed    (results_owed),
    .progress_count  (progress_count),
    .access_idle     (access_idle),
    .access_checking (access_checking)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // sender bursts: each new burst may open with a random gap
  task automatic push_item(input logic [FUNC_W-1:0] fn, input logic data_bit,
                           input logic free_bit, input logic [CW_W-1:0] rnd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid <= 1'b1;
    in_chan.func <= fn;
    in_chan.is_data <= data_bit;
    in_chan.channel_free <= free_bit;
    in_chan.random_value <= rnd;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    burst_left--;
  endtask

  // push the frame to its end, then wait until every result has been taken
  task automatic drain_to_idle();
    int turn;
    turn = 0;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (access_idle !== 1'b1) begin
      if (access_checking === 1'b1) begin
        push_item(FN_CHECK_RES, 1'($urandom), 1'b1, CW_W'($urandom));
      end else begin
        case (turn % 2)
          0: push_item(FN_BURST_ACK, 1'($urandom), 1'($urandom), CW_W'($urandom));
          default: push_item(FN_TICK, 1'($urandom), 1'($urandom), CW_W'($urandom));
        endcase
        turn++;
      end
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
  endtask

  task automatic program_settings(input cfg_t s);
    cfg_write(REG_CCA_ENABLE, CDATA_W'(s.cca_enable));
    cfg_write(REG_DCF_MODE, CDATA_W'(s.dcf_mode));
    cfg_write(REG_POST_TX_BO, CDATA_W'(s.post_tx_backoff_enable));
    cfg_write(REG_BURST_ACK_EN, CDATA_W'(s.burst_ack_enable));
    cfg_write(REG_MIN_CW, CDATA_W'(s.min_cw));
    cfg_write(REG_SLOT_TIME, CDATA_W'(s.slot_time));
    cfg_write(REG_DIFS_TIME, CDATA_W'(s.difs_time));
    cfg_chan.valid <= 1'b0;
  endtask

  // one frame worth of traffic: request, ack, ticks, check results, some noise
  task automatic frame_exchange();
    int n;
    if ($urandom_range(0, 4) == 0)
      push_item(FN_BURST_ACK, 1'($urandom), 1'($urandom), CW_W'($urandom));
    push_item(FN_FRAME_REQ, $urandom_range(0, 3) != 0, 1'($urandom), CW_W'($urandom));
    if ($urandom_range(0, 2) != 0)
      push_item(FN_BURST_ACK, 1'($urandom), 1'($urandom), CW_W'($urandom));
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
    repeat (n) push_item(FN_TICK, 1'($urandom), 1'($urandom), CW_W'($urandom));
    n = $urandom_range(1, 8);
    // mostly small draws so slot countdowns in a wide window stay short
    repeat (n)
      push_item(FN_CHECK_RES, 1'($urandom), $urandom_range(0, 3) != 0,
                ($urandom_range(0, 7) == 0) ? CW_W'($urandom) : CW_W'($urandom_range(0, 31)));
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n)
        push_item(FUNC_W'($urandom), 1'($urandom), 1'($urandom), CW_W'($urandom));
    end
  endtask

  // receiver: own stall pattern plus a long hold-off on request
  initial begin
    int       seg;
    int       holds_done;
    rx_mode_e mode;
    holds_done = 0;
    out_chan.ready <= 1'b0;
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = rx_mode_e'($urandom_range(0, 2));
        seg = (mode == RX_STALL) ? $urandom_range(1, 6) : $urandom_range(1, 24);
        repeat (seg) begin
          case (mode)
            RX_STREAM: out_chan.ready <= 1'b1;
            RX_JITTER: out_chan.ready <= 1'($urandom);
            default:   out_chan.ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int goal;
    plans[0] = '{1'b1, 1'b1, 1'b1, 1'b1, 10'd3, 16'd2, 16'd0};
    plans[1] = '{1'b1, 1'b0, 1'b1, 1'b1, 10'd7, 16'd1, 16'd65535};
    // wide window with long slots; post wait off so it cannot run away
    plans[2] = '{1'b1, 1'b1, 1'b0, 1'b1, 10'd1023, 16'd65535, 16'd1234};
    plans[3] = '{1'b0, 1'b1, 1'b1, 1'b0, 10'd0, 16'd65535, 16'd500};
    plans[4] = '{1'b1, 1'b1, 1'b1, 1'b0, 10'd1, 16'd3, 16'd65535};
    plans[5] = '{1'b0, 1'b0, 1'b1, 1'b1, 10'd15, 16'd4, 16'd7};
    plans[6] = '{1'b1, 1'b1, 1'b1, 1'b1, 10'd3, 16'd1, 16'd16};

    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.func <= FN_TICK;
    in_chan.is_data <= 1'b0;
    in_chan.channel_free <= 1'b0;
    in_chan.random_value <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= REG_CCA_ENABLE;
    cfg_chan.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; draws masked to zero keep the post wait short
    push_item(FN_TICK, 1'b0, 1'b0, 10'h000);
    push_item(FN_CHECK_RES, 1'b0, 1'b1, 10'h000);  // no check outstanding
    push_item(FN_BURST_ACK, 1'b0, 1'b0, 10'h000);  // nothing owed
    push_item(FN_FRAME_REQ, 1'b0, 1'b0, 10'h3FF);  // non-data goes out at once
    push_item(FN_FRAME_REQ, 1'b1, 1'b0, 10'h3E0);
    push_item(FN_FRAME_REQ, 1'b1, 1'b1, 10'h3FF);  // busy, dropped
    push_item(FN_CHECK_RES, 1'b0, 1'b1, 10'h3E0);
    push_item(FN_BURST_ACK, 1'b1, 1'b1, 10'h3FF);  // ack ahead of the next request
    push_item(FN_FRAME_REQ, 1'b1, 1'b0, 10'h155);
    push_item(FN_CHECK_RES, 1'b1, 1'b0, 10'h002);
    push_item(FN_CHECK_RES, 1'b0, 1'b0, 10'h3FF);  // busy slot repeats
    push_item(FN_CHECK_RES, 1'b0, 1'b1, 10'h2AA);
    push_item(FN_CHECK_RES, 1'b1, 1'b1, 10'h3E0);
    push_item(FN_FRAME_REQ, 1'b1, 1'b0, 10'h000);  // waits on the owed ack
    push_item(FN_BURST_ACK, 1'b0, 1'b0, 10'h3E0);
    push_item(FN_CHECK_RES, 1'b0, 1'b0, 10'h3E0);  // busy with a zero draw
    push_item(FN_BURST_ACK, 1'b0, 1'b0, 10'h000);
    push_item(FN_FRAME_REQ, 1'b0, 1'b1, 10'h3FF);
    push_item(FN_TICK, 1'b1, 1'b1, 10'h3FF);
    drain_to_idle();

    for (int round = 0; round < ROUNDS; round++) begin
      foreach (plans[p]) begin
        program_settings(plans[p]);
        if (p == LONG_HOLD_PLAN)
          hold_requests <= hold_requests + 1;
        goal = progress_count + PHASE_ITEMS;
        while (progress_count < goal) frame_exchange();
        drain_to_idle();
      end
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: csma_backoff_controller.f
+incdir+rtl
rtl/csmab_pkg.sv
rtl/csmab_ifs.sv
rtl/csmab_cfg_regs.sv
rtl/csmab_core.sv
rtl/csma_backoff_controller.sv
bench/csmab_access_checker.sv
bench/tb_csma_backoff_controller.sv
